// ----- rtl/sct_pkg.sv -----
// Shared constants and pipeline types for the sine/cosine Taylor series unit.
package sct_pkg;

  // Number of series terms after x (valid range 3 to 8).
  localparam int unsigned SeriesTerms = 6;
  localparam int unsigned MaxTerms    = 8;

  // Front end: angle offset, magnitude, turn scaling, half-turn fold, radians, square.
  localparam int unsigned FrontStages = 6;
  localparam int unsigned TermStages  = 4;
  // Back end: last accumulate, sign, saturation.
  localparam int unsigned BackStages  = 3;
  localparam int unsigned NumStages   = FrontStages + TermStages * SeriesTerms + BackStages;

  localparam logic [31:0] HalfPiQ24 = 32'd26353589;
  localparam logic [29:0] Inv2PiQ32 = 30'd683565276;
  localparam logic [31:0] TwoPiQ29  = 32'd3373259426;

  // Each divisor (n-1)*n splits into a power of two and an odd factor.
  localparam int unsigned TermShift [MaxTerms] = '{1, 2, 1, 3, 1, 2, 1, 4};
  localparam logic [6:0]  TermOdd   [MaxTerms] = '{7'd3, 7'd5, 7'd21, 7'd9,
                                                   7'd55, 7'd39, 7'd105, 7'd17};

  // Reciprocals of the odd factors, scaled by two to the RecipShift.
  localparam int unsigned RecipShift = 36;
  localparam logic [34:0] TermRecip [MaxTerms] = '{
    35'((64'd1 << RecipShift) / 64'd3),
    35'((64'd1 << RecipShift) / 64'd5),
    35'((64'd1 << RecipShift) / 64'd21),
    35'((64'd1 << RecipShift) / 64'd9),
    35'((64'd1 << RecipShift) / 64'd55),
    35'((64'd1 << RecipShift) / 64'd39),
    35'((64'd1 << RecipShift) / 64'd105),
    35'((64'd1 << RecipShift) / 64'd17)
  };

  localparam logic signed [35:0] SatMax = 36'sd2147483647;
  localparam logic signed [35:0] SatMin = -36'sd2147483648;

  typedef struct packed {
    logic               neg;
    logic signed [32:0] ang;
    logic [31:0]        mag;
    logic [31:0]        frac;
    logic [31:0]        x;
    logic [31:0]        x2;
    logic [32:0]        t;
    logic [35:0]        q;
    logic [52:0]        p_lo;
    logic [52:0]        p_hi;
    logic signed [35:0] acc;
    logic [31:0]        res;
  } pipe_t;

endpackage

// ----- rtl/sine_cosine_taylor_unit.sv -----
// Pipelined fixed-point sine/cosine unit using a degree-13 Taylor series.
//
//   Channel  Direction  Contents
//   s_axis   in         tuser: sine (0) or cosine (1); tdata: angle, signed Q8.24 radians
//   m_axis   out        tdata: result, signed Q2.30
//
// One beat enters per cycle while not stalled; its result passes six front stages,
// four per series term and three at the end. Reset clears the stage valid bits only.
// Each full stage holds while the stage after it is full and stalled, so empty stages
// still fill while the output waits; nothing is dropped or repeated.
module sine_cosine_taylor_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] angle
  input  logic        s_axis_tuser_i,   // [0] req_type
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // [31:0] value
);

  localparam int unsigned Last = sct_pkg::NumStages - 1;
  localparam int unsigned EndBase = sct_pkg::FrontStages
                                    + sct_pkg::TermStages * sct_pkg::SeriesTerms;

  sct_pkg::pipe_t                 st_q [sct_pkg::NumStages];
  sct_pkg::pipe_t                 st_d [sct_pkg::NumStages];
  logic [sct_pkg::NumStages-1:0]  vld_q;
  logic [sct_pkg::NumStages-1:0]  vld_d;
  logic [sct_pkg::NumStages-1:0]  stg_en;

  for (genvar k = 0; k < sct_pkg::NumStages; k++) begin : g_stage
    sct_pkg::pipe_t prev;

    if (k == 0) begin : g_in
      assign prev     = '0;
      assign vld_d[k] = s_axis_tvalid_i;
    end else begin : g_mid
      assign prev     = st_q[k-1];
      assign vld_d[k] = vld_q[k-1];
    end

    if (k == Last) begin : g_en_last
      assign stg_en[k] = ~vld_q[k] | m_axis_tready_i;
    end else begin : g_en_mid
      assign stg_en[k] = ~vld_q[k] | stg_en[k+1];
    end

    if (k == 0) begin : g_offset
      always_comb begin
        st_d[k]     = prev;
        st_d[k].ang = {s_axis_tdata_i[31], s_axis_tdata_i}
                      + (s_axis_tuser_i ? {1'b0, sct_pkg::HalfPiQ24} : 33'd0);
      end
    end else if (k == 1) begin : g_mag
      always_comb begin
        st_d[k]     = prev;
        st_d[k].neg = prev.ang[32];
        st_d[k].mag = prev.ang[32] ? 32'(-prev.ang) : prev.ang[31:0];
      end
    end else if (k == 2) begin : g_turns
      logic [61:0] prod;
      always_comb begin
        prod         = 62'(prev.mag) * 62'(sct_pkg::Inv2PiQ32);
        st_d[k]      = prev;
        st_d[k].frac = prod[55:24];
      end
    end else if (k == 3) begin : g_fold
      // A fraction of one half or more folds down by a half turn with a sign flip.
      always_comb begin
        st_d[k] = prev;
        if (prev.frac[31]) begin
          st_d[k].frac = {1'b0, prev.frac[30:0]};
          st_d[k].neg  = ~prev.neg;
        end
      end
    end else if (k == 4) begin : g_rad
      logic [62:0] prod;
      always_comb begin
        prod        = 63'(prev.frac[30:0]) * 63'(sct_pkg::TwoPiQ29);
        st_d[k]     = prev;
        st_d[k].x   = prod[62:31];
        st_d[k].t   = {1'b0, prod[62:31]};
        st_d[k].acc = signed'({4'b0, prod[62:31]});
      end
    end else if (k == 5) begin : g_square
      logic [63:0] sq;
      always_comb begin
        sq         = 64'(prev.x) * 64'(prev.x);
        st_d[k]    = prev;
        st_d[k].x2 = sq[63:32];
      end
    end else if (k < EndBase) begin : g_term
      localparam int unsigned Idx   = (k - sct_pkg::FrontStages) / sct_pkg::TermStages;
      localparam int unsigned Phase = (k - sct_pkg::FrontStages) % sct_pkg::TermStages;
      // Terms with n = 3 mod 4 are subtracted; those are the even term indexes.
      localparam bit PrevSub = ((Idx % 2) == 1);

      if (Phase == 0) begin : g_mul
        logic [64:0] prod;
        always_comb begin
          prod      = 65'(prev.t) * 65'(prev.x2);
          st_d[k]   = prev;
          st_d[k].q = 36'(prod >> (28 + sct_pkg::TermShift[Idx]));
          // The previous term is folded into the sum here, off the divider path.
          if (Idx > 0) begin
            if (PrevSub) st_d[k].acc = prev.acc - signed'({3'b0, prev.t});
            else         st_d[k].acc = prev.acc + signed'({3'b0, prev.t});
          end
        end
      end else if (Phase == 1) begin : g_recip
        always_comb begin
          st_d[k]      = prev;
          st_d[k].p_lo = 53'(prev.q[17:0])  * 53'(sct_pkg::TermRecip[Idx]);
          st_d[k].p_hi = 53'(prev.q[35:18]) * 53'(sct_pkg::TermRecip[Idx]);
        end
      end else if (Phase == 2) begin : g_quot
        logic [70:0] full;
        always_comb begin
          full      = (71'(prev.p_hi) << 18) + 71'(prev.p_lo);
          st_d[k]   = prev;
          st_d[k].t = full[68:36];
        end
      end else begin : g_fix
        // The reciprocal estimate is low by at most one; the remainder tells.
        logic [39:0] back;
        logic [39:0] rem;
        always_comb begin
          back    = 40'(prev.t) * 40'(sct_pkg::TermOdd[Idx]);
          rem     = 40'(prev.q) - back;
          st_d[k] = prev;
          if (rem >= 40'(sct_pkg::TermOdd[Idx])) st_d[k].t = prev.t + 33'd1;
        end
      end
    end else if (k == EndBase) begin : g_last_term
      localparam bit LastSub = (((sct_pkg::SeriesTerms - 1) % 2) == 0);
      always_comb begin
        st_d[k] = prev;
        if (LastSub) st_d[k].acc = prev.acc - signed'({3'b0, prev.t});
        else         st_d[k].acc = prev.acc + signed'({3'b0, prev.t});
      end
    end else if (k == EndBase + 1) begin : g_sign
      always_comb begin
        st_d[k] = prev;
        if (prev.neg) st_d[k].acc = -prev.acc;
      end
    end else begin : g_sat
      always_comb begin
        st_d[k] = prev;
        if (prev.acc > sct_pkg::SatMax) begin
          st_d[k].res = 32'h7FFF_FFFF;
        end else if (prev.acc < sct_pkg::SatMin) begin
          st_d[k].res = 32'h8000_0000;
        end else begin
          st_d[k].res = prev.acc[31:0];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (stg_en[k]) begin
        vld_q[k] <= vld_d[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (stg_en[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign s_axis_tready_o = stg_en[0];
  assign m_axis_tvalid_o = vld_q[Last];
  assign m_axis_tdata_o  = st_q[Last].res;

endmodule
